>>> hdl/apf_pkg.sv
// ----------------------------------------------------------------------------
// apf_pkg
// Shared types, constants and helpers of the ARIMA process filter.
// ----------------------------------------------------------------------------
package apf_pkg;

    // default sizes of the tap and integrator chains
    localparam int unsigned AR_TAPS_MAX_DEF = 4;
    localparam int unsigned MA_TAPS_MAX_DEF = 4;
    localparam int unsigned DIFF_MAX_DEF    = 2;

    // number of coefficients packed into one coefficient register
    localparam int unsigned COEF_SLOTS = 4;
    localparam int unsigned COEF_W     = 16;

    // widths of the data paths
    localparam int unsigned NOISE_W = 16;
    localparam int unsigned RAW_W   = 24;
    localparam int unsigned SUM_W   = 32;
    localparam int unsigned ORD_W   = 5;
    localparam int unsigned IDX_W   = 3;

    // configuration register indexes
    localparam logic [2:0] CFG_AR_ORDER   = 3'd0;
    localparam logic [2:0] CFG_MA_ORDER   = 3'd1;
    localparam logic [2:0] CFG_DIFF_ORDER = 3'd2;
    localparam logic [2:0] CFG_AR_COEFS   = 3'd3;
    localparam logic [2:0] CFG_MA_COEFS   = 3'd4;

    // input word
    typedef struct packed {
        logic signed [NOISE_W-1:0] noise_sample;
        logic                      first_sample;
    } t_in_word;

    // result word
    typedef struct packed {
        logic signed [SUM_W-1:0] series_value;
        logic                    clipped;
    } t_out_word;

    // word traveling down the integrator chain
    typedef struct packed {
        logic signed [SUM_W-1:0] value;
        logic                    first;
        logic                    clip;
    } t_int_word;

    // control of the tap chain
    typedef struct packed {
        logic shift;
        logic clear;
    } t_tap_ctrl;

    // coefficient of one lag, zero past the packed slots
    function automatic logic signed [COEF_W-1:0] coef_at(
        input logic [COEF_SLOTS*COEF_W-1:0] packed_coefs,
        input int unsigned                  j
    );
        logic signed [COEF_W-1:0] c;
        c = '0;
        for (int unsigned k = 0; k < COEF_SLOTS; k++) begin
            if (k == j) begin
                c = packed_coefs[k*COEF_W +: COEF_W];
            end
        end
        return c;
    endfunction

endpackage

>>> hdl/apf_tap_cell.sv
// ----------------------------------------------------------------------------
// apf_tap_cell
// One history tap: holds one past value, hands it on to the next lag and
// forms its rounded coefficient product.
// ----------------------------------------------------------------------------
module apf_tap_cell #(
    parameter int unsigned DATA_W = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  apf_pkg::t_tap_ctrl                i_ctrl,
    input  logic                              i_on,
    input  logic signed [apf_pkg::COEF_W-1:0] i_coef,
    input  logic signed [DATA_W-1:0]          i_data,
    output logic signed [DATA_W-1:0]          o_data,
    output logic signed [DATA_W+1:0]          o_prod
);
    import apf_pkg::*;

    localparam int unsigned PROD_W = DATA_W + COEF_W;

    logic signed [DATA_W-1:0] r_data;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_rnd;

    // a restart makes the whole history read as zero
    assign o_data = i_ctrl.clear ? '0 : r_data;

    // product rounded half up to the data's fraction
    assign w_prod = i_coef * o_data;
    assign w_rnd  = w_prod + PROD_W'(signed'(1 << (COEF_W - 3)));
    assign o_prod = i_on ? w_rnd[PROD_W-1:COEF_W-2] : '0;

    // history register, moves one lag per accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_ctrl.shift) begin
            r_data <= i_data;
        end
    end

endmodule

>>> hdl/apf_int_cell.sv
// ----------------------------------------------------------------------------
// apf_int_cell
// One running-sum integrator stage with saturation and its own output
// register, part of the elastic integrator chain.
// ----------------------------------------------------------------------------
module apf_int_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_active,
    input  logic               i_valid,
    input  apf_pkg::t_int_word i_word,
    output logic               o_ready,
    input  logic               i_ready_next,
    output logic               o_valid,
    output apf_pkg::t_int_word o_word
);
    import apf_pkg::*;

    localparam logic signed [SUM_W:0] SUM_HI = (SUM_W+1)'({1'b0, {(SUM_W-1){1'b1}}});
    localparam logic signed [SUM_W:0] SUM_LO = -SUM_HI - (SUM_W+1)'(1);

    logic                    r_valid;
    t_int_word               r_word;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;
    t_int_word               n_word;
    logic signed [SUM_W-1:0] w_base;
    logic signed [SUM_W:0]   w_add;
    logic                    w_load;

    assign o_ready = !r_valid || i_ready_next;
    assign w_load  = o_ready && i_valid;
    assign o_valid = r_valid;
    assign o_word  = r_word;

    // add and saturate, or pass through when this stage is unused
    always_comb begin
        w_base = i_word.first ? '0 : r_sum;
        w_add  = (SUM_W+1)'(w_base) + (SUM_W+1)'(i_word.value);
        n_word = i_word;
        n_sum  = w_base;
        if (i_active) begin
            if (w_add > SUM_HI) begin
                n_sum       = SUM_HI[SUM_W-1:0];
                n_word.clip = 1'b1;
            end else if (w_add < SUM_LO) begin
                n_sum       = SUM_LO[SUM_W-1:0];
                n_word.clip = 1'b1;
            end else begin
                n_sum = w_add[SUM_W-1:0];
            end
            n_word.value = n_sum;
        end
    end

    // stage register and running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sum   <= '0;
        end else if (o_ready) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_sum <= n_sum;
            end
        end
    end

    // payload of the stage
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_word <= n_word;
        end
    end

endmodule

>>> hdl/arima_process_filter.sv
// ----------------------------------------------------------------------------
// arima_process_filter
// ARIMA(p,d,q) series filter: AR/MA tap chain feeding a chain of saturating
// integrators, one word in and one word out per clock when nothing stalls.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_stall   i_in_word  (t_in_word)
//  out       output     o_out_valid / i_out_stall o_out_word (t_out_word)
//  cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
//  One word per clock sustained while the output is not stalled; a word is
//  registered in the tap sum stage and again in each integrator cell.
//  The raw value is formed in the cycle a word is accepted, since it feeds
//  back into the AR history for the next word.
//  Reset clears configuration, histories, integrator sums and all valid bits.
//  Each stage holds its word under stall and takes a new one as soon as its
//  successor is free, so bubbles close up and input stalls only when full.
// ----------------------------------------------------------------------------
module arima_process_filter #(
    parameter int unsigned AR_TAPS_MAX = apf_pkg::AR_TAPS_MAX_DEF,
    parameter int unsigned MA_TAPS_MAX = apf_pkg::MA_TAPS_MAX_DEF,
    parameter int unsigned DIFF_MAX    = apf_pkg::DIFF_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  apf_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output apf_pkg::t_out_word o_out_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [63:0]        i_cfg_data
);
    import apf_pkg::*;

    localparam int unsigned AR_P_W = RAW_W + 2;
    localparam int unsigned MA_P_W = NOISE_W + 2;
    localparam int unsigned ACC_W  = AR_P_W + $clog2(AR_TAPS_MAX + MA_TAPS_MAX + 1) + 1;
    localparam int unsigned D_W    = 3;
    localparam logic signed [ACC_W-1:0] RAW_HI = ACC_W'((1 << (RAW_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] RAW_LO = -RAW_HI - ACC_W'(1);
    localparam logic [IDX_W-1:0] IDX_LAST = '1;

    // configuration registers
    logic [2:0]  r_ar_order;
    logic [2:0]  r_ma_order;
    logic [1:0]  r_diff_order;
    logic [63:0] r_ar_coefs;
    logic [63:0] r_ma_coefs;

    // series index and sum stage
    logic [IDX_W-1:0] r_index;
    logic [IDX_W-1:0] n_index;
    logic             r_s0_valid;
    t_int_word        r_s0_word;
    t_int_word        n_s0_word;

    logic            w_accept;
    logic            w_s0_ready;
    t_tap_ctrl       w_tap_ctrl;
    logic [ORD_W-1:0] w_p_eff;
    logic [ORD_W-1:0] w_q_eff;
    logic [ORD_W-1:0] w_start;
    logic [D_W-1:0]   w_d_eff;
    logic [IDX_W-1:0] w_idx_eff;
    logic signed [ACC_W-1:0] w_acc;
    logic signed [RAW_W-1:0] w_raw;
    logic                    w_raw_clip;

    logic signed [RAW_W-1:0]   w_ar_data [AR_TAPS_MAX];
    logic signed [AR_P_W-1:0]  w_ar_prod [AR_TAPS_MAX];
    logic signed [NOISE_W-1:0] w_ma_data [MA_TAPS_MAX];
    logic signed [MA_P_W-1:0]  w_ma_prod [MA_TAPS_MAX];

    logic      w_int_valid [DIFF_MAX+1];
    t_int_word w_int_word  [DIFF_MAX+1];
    logic      w_int_ready [DIFF_MAX+1];

    // configuration writes, always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ar_order   <= '0;
            r_ma_order   <= '0;
            r_diff_order <= '0;
            r_ar_coefs   <= '0;
            r_ma_coefs   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_AR_ORDER:   r_ar_order   <= i_cfg_data[2:0];
                CFG_MA_ORDER:   r_ma_order   <= i_cfg_data[2:0];
                CFG_DIFF_ORDER: r_diff_order <= i_cfg_data[1:0];
                CFG_AR_COEFS:   r_ar_coefs   <= i_cfg_data;
                CFG_MA_COEFS:   r_ma_coefs   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input handshake
    assign w_s0_ready = !r_s0_valid || w_int_ready[0];
    assign o_in_stall = !w_s0_ready;
    assign w_accept   = i_in_valid && w_s0_ready;

    assign w_tap_ctrl.shift = w_accept;
    assign w_tap_ctrl.clear = i_in_word.first_sample;

    // AR tap chain over past raw values
    for (genvar j = 0; j < AR_TAPS_MAX; j++) begin : g_ar
        logic signed [RAW_W-1:0] w_in;
        if (j == 0) begin : g_head
            assign w_in = w_raw;
        end else begin : g_link
            assign w_in = w_ar_data[j-1];
        end
        apf_tap_cell #(
            .DATA_W (RAW_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_tap_ctrl),
            .i_on    (ORD_W'(r_ar_order) > ORD_W'(j)),
            .i_coef  (coef_at(r_ar_coefs, j)),
            .i_data  (w_in),
            .o_data  (w_ar_data[j]),
            .o_prod  (w_ar_prod[j])
        );
    end

    // MA tap chain over past noise samples
    for (genvar j = 0; j < MA_TAPS_MAX; j++) begin : g_ma
        logic signed [NOISE_W-1:0] w_in;
        if (j == 0) begin : g_head
            assign w_in = i_in_word.noise_sample;
        end else begin : g_link
            assign w_in = w_ma_data[j-1];
        end
        apf_tap_cell #(
            .DATA_W (NOISE_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_tap_ctrl),
            .i_on    (ORD_W'(r_ma_order) > ORD_W'(j)),
            .i_coef  (coef_at(r_ma_coefs, j)),
            .i_data  (w_in),
            .o_data  (w_ma_data[j]),
            .o_prod  (w_ma_prod[j])
        );
    end

    // effective orders and series index
    always_comb begin
        w_p_eff = (ORD_W'(r_ar_order) > ORD_W'(AR_TAPS_MAX)) ?
                  ORD_W'(AR_TAPS_MAX) : ORD_W'(r_ar_order);
        w_q_eff = (ORD_W'(r_ma_order) > ORD_W'(MA_TAPS_MAX)) ?
                  ORD_W'(MA_TAPS_MAX) : ORD_W'(r_ma_order);
        w_start = (w_p_eff > w_q_eff) ? w_p_eff : w_q_eff;
        w_d_eff = (D_W'(r_diff_order) > D_W'(DIFF_MAX)) ?
                  D_W'(DIFF_MAX) : D_W'(r_diff_order);
        w_idx_eff = i_in_word.first_sample ? '0 : r_index;
    end

    // tap sum and raw value
    always_comb begin
        w_acc = ACC_W'(i_in_word.noise_sample);
        for (int j = 0; j < AR_TAPS_MAX; j++) begin
            w_acc = w_acc + ACC_W'(w_ar_prod[j]);
        end
        for (int j = 0; j < MA_TAPS_MAX; j++) begin
            w_acc = w_acc + ACC_W'(w_ma_prod[j]);
        end
        w_raw_clip = 1'b0;
        if (ORD_W'(w_idx_eff) < w_start) begin
            w_raw = (D_W'(w_idx_eff) < w_d_eff) ? RAW_W'(i_in_word.noise_sample) : '0;
        end else if (w_acc > RAW_HI) begin
            w_raw      = RAW_HI[RAW_W-1:0];
            w_raw_clip = 1'b1;
        end else if (w_acc < RAW_LO) begin
            w_raw      = RAW_LO[RAW_W-1:0];
            w_raw_clip = 1'b1;
        end else begin
            w_raw = w_acc[RAW_W-1:0];
        end
    end

    // next index, saturating at its top value
    always_comb begin
        n_index = (w_idx_eff == IDX_LAST) ? IDX_LAST : w_idx_eff + IDX_W'(1);
        n_s0_word.value = SUM_W'(w_raw);
        n_s0_word.first = i_in_word.first_sample;
        n_s0_word.clip  = w_raw_clip;
    end

    // sum stage register and index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_index    <= '0;
        end else begin
            if (w_s0_ready) begin
                r_s0_valid <= i_in_valid;
            end
            if (w_accept) begin
                r_index <= n_index;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s0_word <= n_s0_word;
        end
    end

    // integrator chain
    assign w_int_valid[0] = r_s0_valid;
    assign w_int_word[0]  = r_s0_word;

    for (genvar j = 0; j < DIFF_MAX; j++) begin : g_int
        apf_int_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_active     (D_W'(r_diff_order) > D_W'(j)),
            .i_valid      (w_int_valid[j]),
            .i_word       (w_int_word[j]),
            .o_ready      (w_int_ready[j]),
            .i_ready_next (w_int_ready[j+1]),
            .o_valid      (w_int_valid[j+1]),
            .o_word       (w_int_word[j+1])
        );
    end

    // output word
    assign w_int_ready[DIFF_MAX]   = !i_out_stall;
    assign o_out_valid             = w_int_valid[DIFF_MAX];
    assign o_out_word.series_value = w_int_word[DIFF_MAX].value;
    assign o_out_word.clipped      = w_int_word[DIFF_MAX].clip;

`ifndef SYNTHESIS
    // a restart leaves the index at one
    a_restart_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in_word.first_sample |=> r_index == IDX_W'(1))
        else $error("index not restarted");

    // the index moves only on an accepted word
    a_index_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_index))
        else $error("index moved without a word");

    // input stalls only with a word held in the sum stage
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s0_valid)
        else $error("input stalled with empty sum stage");

    // the raw value stays inside its saturated range
    a_raw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s0_valid |-> (r_s0_word.value[SUM_W-1:RAW_W-1] == '0 ||
                        r_s0_word.value[SUM_W-1:RAW_W-1] == '1))
        else $error("raw value outside 24-bit range");
`endif

endmodule

>>> dv/tb_arima_process_filter.sv
// ----------------------------------------------------------------------------
// tb_arima_process_filter
// Self-checking bench for the ARIMA process filter. A queue-fed driver offers
// noise words with random gaps, a monitor predicts each accepted word with a
// bit-exact copy of the filter arithmetic and checks every result word in
// order. Register settings change between phases while the filter is idle.
// ----------------------------------------------------------------------------
module tb_arima_process_filter;
    timeunit 1ns;
    timeprecision 1ps;

    import apf_pkg::*;

    localparam int AR_TAPS  = AR_TAPS_MAX_DEF;
    localparam int MA_TAPS  = MA_TAPS_MAX_DEF;
    localparam int DIFF_CNT = DIFF_MAX_DEF;

    // register indexes past the implemented list, writes must be dropped
    localparam logic [2:0] CFG_SPARE_LO = 3'd5;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    localparam longint RAW_HI = (64'sd1 <<< (RAW_W - 1)) - 1;
    localparam longint RAW_LO = -(64'sd1 <<< (RAW_W - 1));
    localparam longint SUM_HI = (64'sd1 <<< (SUM_W - 1)) - 1;
    localparam longint SUM_LO = -(64'sd1 <<< (SUM_W - 1));

    localparam int ITEM_GOAL   = 1250;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PCT    = 25;
    localparam int CYCLE_LIMIT = 200000;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // block ports
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_in_word    in_word   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_word   out_word;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data  = '0;

    arima_process_filter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // bench bookkeeping
    t_in_word  noise_backlog[$];
    t_out_word series_expected[$];
    logic      in_took     = 1'b0;
    bit        steady      = 1'b0;
    int        hold_ask    = 0;
    int        hold_seen   = 0;
    int        hold_left   = 0;
    int        mismatches  = 0;
    int        cycle_count = 0;
    int        items_queued = 0;

    // shadow registers and filter state
    logic [2:0]  m_ar_order   = '0;
    logic [2:0]  m_ma_order   = '0;
    logic [1:0]  m_diff_order = '0;
    logic [63:0] m_ar_coefs   = '0;
    logic [63:0] m_ma_coefs   = '0;
    logic [IDX_W-1:0]          m_index = '0;
    logic signed [RAW_W-1:0]   raw_hist[AR_TAPS]    = '{default: '0};
    logic signed [NOISE_W-1:0] noise_hist[MA_TAPS]  = '{default: '0};
    logic signed [SUM_W-1:0]   integ_sum[DIFF_CNT]  = '{default: '0};

    // Q1.14 by Q.12 product rounded back to Q.12, floor after adding half
    function automatic longint tap_round(longint c, longint x);
        return (c * x + 64'sd8192) >>> 14;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi, inout bit flag);
        if (v > hi) begin
            flag = 1'b1;
            return hi;
        end
        if (v < lo) begin
            flag = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // one filter step: raw value, history shift, integrator cascade
    function automatic t_out_word arima_step(t_in_word w);
        t_out_word res;
        longint acc;
        longint run;
        bit clip;
        int p, q, d, span;
        logic signed [COEF_W-1:0] c;
        clip = 1'b0;
        p = int'(m_ar_order);
        q = int'(m_ma_order);
        d = int'(m_diff_order);
        if (p > AR_TAPS) p = AR_TAPS;
        if (q > MA_TAPS) q = MA_TAPS;
        if (d > DIFF_CNT) d = DIFF_CNT;
        if (w.first_sample) begin
            m_index = '0;
            foreach (raw_hist[j]) raw_hist[j] = '0;
            foreach (noise_hist[j]) noise_hist[j] = '0;
            foreach (integ_sum[j]) integ_sum[j] = '0;
        end
        span = (p > q) ? p : q;
        // warm-up: leading noise for the first d words, zero after that
        if (int'(m_index) < span) begin
            acc = (int'(m_index) < d) ? longint'(w.noise_sample) : 64'sd0;
        end else begin
            acc = w.noise_sample;
            for (int j = 0; j < p; j++) begin
                c = m_ar_coefs[j*COEF_W +: COEF_W];
                acc += tap_round(c, raw_hist[j]);
            end
            for (int j = 0; j < q; j++) begin
                c = m_ma_coefs[j*COEF_W +: COEF_W];
                acc += tap_round(c, noise_hist[j]);
            end
            acc = clamp(acc, RAW_LO, RAW_HI, clip);
        end
        for (int j = AR_TAPS - 1; j > 0; j--) raw_hist[j] = raw_hist[j-1];
        raw_hist[0] = acc[RAW_W-1:0];
        for (int j = MA_TAPS - 1; j > 0; j--) noise_hist[j] = noise_hist[j-1];
        noise_hist[0] = w.noise_sample;
        // integrator cascade, unused cells keep their sums
        run = acc;
        for (int j = 0; j < d; j++) begin
            run = clamp(longint'(integ_sum[j]) + run, SUM_LO, SUM_HI, clip);
            integ_sum[j] = run[SUM_W-1:0];
        end
        if (m_index != '1) m_index++;
        res.series_value = run[SUM_W-1:0];
        res.clipped      = clip;
        return res;
    endfunction

    task automatic report_mismatch(string what, t_out_word want, t_out_word got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("[%0t] %s: expected value %0d clipped %0b, got value %0d clipped %0b",
                     $realtime, what, want.series_value, want.clipped,
                     got.series_value, got.clipped);
        end
    endtask

    // input acceptance, prediction, output check and watchdog
    always @(posedge i_clk) begin
        t_out_word want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            in_took <= i_rst_n && in_valid && !in_stall;
            if (i_rst_n) begin
                if (in_valid && !in_stall) begin
                    series_expected.push_back(arima_step(in_word));
                end
                if (out_valid && !out_stall) begin
                    if (series_expected.size() == 0) begin
                        report_mismatch("unexpected word", '0, out_word);
                    end else begin
                        want = series_expected.pop_front();
                        if (out_word.series_value !== want.series_value ||
                            out_word.clipped !== want.clipped) begin
                            report_mismatch("word mismatch", want, out_word);
                        end
                    end
                end
            end
        end
    end

    // input driver, holds a stalled word, random gaps between words
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (in_valid && !in_took) begin
            in_valid <= 1'b1;
        end else if (noise_backlog.size() > 0 &&
                     (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
            in_word  <= noise_backlog.pop_front();
            in_valid <= 1'b1;
        end else begin
            in_valid <= 1'b0;
        end
    end

    // output stall: random, or one long hold when asked
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_ask != hold_seen) begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // register write, shadow copy updated when the write lands
    task automatic cfg_write(logic [2:0] idx, logic [63:0] value);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            CFG_AR_ORDER:   m_ar_order   = value[2:0];
            CFG_MA_ORDER:   m_ma_order   = value[2:0];
            CFG_DIFF_ORDER: m_diff_order = value[1:0];
            CFG_AR_COEFS:   m_ar_coefs   = value;
            CFG_MA_COEFS:   m_ma_coefs   = value;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // wait until every queued word went in and every result came out
    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #0.2;
        end while (noise_backlog.size() != 0 || series_expected.size() != 0 || in_valid);
    endtask

    task automatic queue_word(logic signed [NOISE_W-1:0] noise, logic first);
        t_in_word w;
        w.noise_sample = noise;
        w.first_sample = first;
        noise_backlog.push_back(w);
        items_queued++;
    endtask

    // mostly moderate noise, some full range, some extremes
    function automatic logic signed [NOISE_W-1:0] pick_noise();
        int r;
        logic signed [NOISE_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 8) v = {1'b0, {(NOISE_W-1){1'b1}}};
        else if (r < 16) v = {1'b1, {(NOISE_W-1){1'b0}}};
        else if (r < 40) v = NOISE_W'($urandom);
        else v = NOISE_W'(int'($urandom_range(0, 8191)) - 4096);
        return v;
    endfunction

    // full random, mild (mostly stable), or extreme coefficient sets
    function automatic logic [63:0] pick_coefs();
        logic [63:0] v;
        case ($urandom_range(0, 3))
            0: v = {$urandom, $urandom};
            3: begin
                for (int k = 0; k < COEF_SLOTS; k++) begin
                    case ($urandom_range(0, 3))
                        0: v[k*COEF_W +: COEF_W] = 16'h7FFF;
                        1: v[k*COEF_W +: COEF_W] = 16'h8000;
                        2: v[k*COEF_W +: COEF_W] = 16'h0000;
                        default: v[k*COEF_W +: COEF_W] = 16'h4000;
                    endcase
                end
            end
            default: begin
                for (int k = 0; k < COEF_SLOTS; k++) begin
                    v[k*COEF_W +: COEF_W] =
                        COEF_W'(int'($urandom_range(0, 6143)) - 3072);
                end
            end
        endcase
        return v;
    endfunction

    // order value in the low bits, junk above
    function automatic logic [63:0] order_word(logic [2:0] ord);
        logic [63:0] v;
        v = {$urandom, $urandom};
        v[2:0] = ord;
        return v;
    endfunction

    // stimulus sequence
    initial begin
        int phase;
        int len;
        bit cont;
        phase = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: raw value is the noise itself
        queue_word(16'sh7FFF, 1'b1);
        queue_word(16'sh8000, 1'b0);
        queue_word(16'sh0000, 1'b0);
        queue_word(16'sh0001, 1'b0);
        queue_word(-16'sh0001, 1'b0);
        wait_drained();

        // full order, extreme coefficients, warm-up then saturation
        cfg_write(CFG_AR_ORDER, 64'd4);
        cfg_write(CFG_MA_ORDER, 64'd4);
        cfg_write(CFG_DIFF_ORDER, 64'd2);
        cfg_write(CFG_AR_COEFS, 64'h7FFF_7FFF_7FFF_7FFF);
        cfg_write(CFG_MA_COEFS, 64'h8000_8000_8000_8000);
        queue_word(16'sh7FFF, 1'b1);
        repeat (7) queue_word(16'sh7FFF, 1'b0);
        queue_word(16'sh8000, 1'b0);
        wait_drained();

        // orders above the maximum, dropped writes, restart mid-series
        cfg_write(CFG_AR_ORDER, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(CFG_MA_ORDER, 64'd5);
        cfg_write(CFG_DIFF_ORDER, 64'd3);
        cfg_write(CFG_AR_COEFS, 64'h8000_8000_8000_8000);
        cfg_write(CFG_MA_COEFS, 64'h7FFF_7FFF_7FFF_7FFF);
        cfg_write(CFG_SPARE_LO, 64'hDEAD_BEEF_0000_0001);
        cfg_write(CFG_SPARE_HI, 64'h0000_0000_0000_0003);
        queue_word(16'sh8000, 1'b1);
        queue_word(16'sh8000, 1'b0);
        queue_word(16'sh0000, 1'b0);
        queue_word(16'sh0001, 1'b0);
        queue_word(-16'sh0001, 1'b0);
        queue_word(16'sh0064, 1'b1);
        queue_word(16'sh00C8, 1'b0);
        wait_drained();

        // random phases: new settings, then series with random content
        while (items_queued < ITEM_GOAL) begin
            cfg_write(CFG_AR_ORDER, order_word(3'($urandom_range(0, 7))));
            cfg_write(CFG_MA_ORDER, order_word(3'($urandom_range(0, 7))));
            cfg_write(CFG_DIFF_ORDER, order_word(3'($urandom_range(0, 7))));
            cfg_write(CFG_AR_COEFS, pick_coefs());
            cfg_write(CFG_MA_COEFS, pick_coefs());
            if ($urandom_range(0, 3) == 0) begin
                cfg_write(3'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO)),
                          {$urandom, $urandom});
            end
            steady = (phase == 3);
            if (phase == 1) hold_ask++;
            repeat ($urandom_range(1, 4) + ((phase == 1) ? 2 : 0)) begin
                len  = $urandom_range(1, 40);
                // a few series run on from the previous one without a restart
                cont = ($urandom_range(0, 9) == 0);
                for (int k = 0; k < len; k++) begin
                    queue_word(pick_noise(),
                               (k == 0 && !cont) || ($urandom_range(0, 49) == 0));
                end
            end
            wait_drained();
            steady = 1'b0;
            phase++;
        end

        repeat (DIFF_CNT + 4) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
